### rtl/nfts_pkg.sv
// Package for the NOR flash toggle-bit status poller.
// Holds the phase, check, status and result codes and the DQ lane masks.
// No dependencies.
package nfts_pkg;

    // Read phases of one poll.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_P1_R1  = 3'd1;
    localparam logic [2:0] PH_P1_R2  = 3'd2;
    localparam logic [2:0] PH_P2_R1  = 3'd3;
    localparam logic [2:0] PH_P2_R2  = 3'd4;
    localparam logic [2:0] PH_VERIFY = 3'd5;

    // Recheck that the second read pair performs.
    localparam logic [1:0] CHK_NONE    = 2'd0;
    localparam logic [1:0] CHK_ABORT   = 2'd1;
    localparam logic [1:0] CHK_TIMEOUT = 2'd2;
    localparam logic [1:0] CHK_DQ2     = 2'd3;

    // Attempt status codes.
    localparam logic [2:0] ST_READY     = 3'd0;
    localparam logic [2:0] ST_ABORT     = 3'd1;
    localparam logic [2:0] ST_TIMEOUT   = 3'd2;
    localparam logic [2:0] ST_SUSPENDED = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_BUSY      = 3'd5;

    // Result outcome codes.
    localparam logic [1:0] OUT_OK      = 2'd0;
    localparam logic [1:0] OUT_ABORTED = 2'd1;
    localparam logic [1:0] OUT_FAILED  = 2'd2;

    // Result cause codes.
    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_ABORT     = 3'd1;
    localparam logic [2:0] CAUSE_TIMEOUT   = 3'd2;
    localparam logic [2:0] CAUSE_SUSPENDED = 3'd3;
    localparam logic [2:0] CAUSE_EXHAUSTED = 3'd4;
    localparam logic [2:0] CAUSE_MISMATCH  = 3'd5;

    // Configuration register indexes.
    localparam logic REG_PAIRED_MODE   = 1'b0;
    localparam logic REG_ATTEMPT_LIMIT = 1'b1;

    // Status bits of one x16 device.
    localparam logic [31:0] DQ1_BIT = 32'h0000_0002;
    localparam logic [31:0] DQ2_BIT = 32'h0000_0004;
    localparam logic [31:0] DQ5_BIT = 32'h0000_0020;
    localparam logic [31:0] DQ6_BIT = 32'h0000_0040;

    // Outcome of the evaluation logic for the current read.
    typedef struct packed {
        logic [1:0] p1_check;   // recheck chosen after pair one, none means busy
        logic [2:0] p2_status;  // attempt status after pair two
        logic       verify_ok;  // final read matches expected data
    } eval_t;

    // Extend a status bit to the upper device when two devices are paired.
    function automatic logic [31:0] lane_mask(input logic paired, input logic [31:0] bit_mask);
        lane_mask = paired ? (bit_mask | (bit_mask << 16)) : bit_mask;
    endfunction

    // Bits of the data bus that carry device data.
    function automatic logic [31:0] bus_mask(input logic paired);
        bus_mask = paired ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    endfunction

endpackage

### rtl/nfts_eval.sv
// Status evaluation logic for the NOR flash toggle-bit poller.
// Classifies read pairs and checks the final verify read.
// Depends on nfts_pkg.
module nfts_eval
    import nfts_pkg::*;
(
    input  logic        paired,
    input  logic        buffer_mode,
    input  logic [1:0]  pending_check,
    input  logic [31:0] first_read,
    input  logic [31:0] expected_held,
    input  logic [31:0] r,
    output eval_t       eval
);

    logic [31:0] m6;
    logic [31:0] m2;
    logic [31:0] mk;
    logic [31:0] t;
    logic [31:0] d2;
    logic [31:0] hit;
    logic [1:0]  p1_check;
    logic [2:0]  p2_status;
    logic        verify_ok;

    // Toggle word of the current pair and masks for this bus width.
    assign m6 = lane_mask(paired, DQ6_BIT);
    assign m2 = lane_mask(paired, DQ2_BIT);
    assign mk = lane_mask(paired, (pending_check == CHK_ABORT) ? DQ1_BIT : DQ5_BIT);
    assign t  = (first_read ^ r) & m6;
    assign d2 = (first_read ^ r) & m2;
    assign hit = (pending_check == CHK_ABORT) ? (t >> 5) : (t >> 1);

    // Decision after the first pair.
    always_comb
    begin
        if (t != 32'd0) begin
            if (buffer_mode && (((t >> 5) & r) != 32'd0)) begin
                p1_check = CHK_ABORT;
            end else if (((t >> 1) & r) != 32'd0) begin
                p1_check = CHK_TIMEOUT;
            end else begin
                p1_check = CHK_NONE;
            end
        end else begin
            p1_check = CHK_DQ2;
        end
    end

    // Decision after the second pair.
    always_comb
    begin
        if (pending_check == CHK_DQ2) begin
            if (d2 == m2) begin
                p2_status = ST_SUSPENDED;
            end else if (d2 == 32'd0) begin
                p2_status = ST_READY;
            end else begin
                p2_status = ST_BUSY;
            end
        end else if ((t != 32'd0) && ((hit & r) != 32'd0) && (hit == (r & mk))) begin
            p2_status = (pending_check == CHK_ABORT) ? ST_ABORT : ST_TIMEOUT;
        end else begin
            p2_status = ST_BUSY;
        end
    end

    // Verify of the final read against the programmed data.
    assign verify_ok = ((expected_held & bus_mask(paired)) == r);

    assign eval = {p1_check, p2_status, verify_ok};

endmodule

### rtl/nor_flash_toggle_status_poller_unit.sv
// Top level of the NOR flash toggle-bit status poller.
// Holds the poll state, configuration and result register.
// Depends on nfts_pkg and nfts_eval.
//
// Usage: after a program operation, feed each status read of the polled
// location on the input channel (in_valid/in_ready), with start_req set on
// the first read of a poll. Every input item yields exactly one result item
// on the output channel (out_valid/out_ready): done_res 0 asks for the next
// read, done_res 1 ends the poll with outcome and cause.
// out_valid rises in the cycle after acceptance. One item is accepted
// every cycle while the result register is free or being emptied; the state
// update and classification fit between the input handshake and the result
// register, and the 32-bit attempt decrement is the widest path.
// When the receiver stalls, the result register holds its item and the
// input is still taken in the same cycle the waiting result leaves.
// Configuration (cfg_we, cfg_index, cfg_data) is for the user to write only
// while idle; the block does not enforce it. Index 0 is paired_mode, index 1
// is attempt_limit. Reset clears the poll to idle, paired_mode to 0 and
// attempt_limit to all ones, and empties the result register.
module nor_flash_toggle_status_poller_unit
    import nfts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_req,
    input  logic        buffer_write,
    input  logic [31:0] expected_data,
    input  logic [31:0] read_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        done_res,
    output logic [1:0]  outcome,
    output logic [2:0]  cause
);

    logic        paired_reg;
    logic [31:0] limit_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  pending_reg, pending_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] attempts_reg, attempts_next;
    logic [31:0] expected_reg, expected_next;
    logic        bufmode_reg, bufmode_next;
    logic [2:0]  final_reg, final_next;

    logic        out_valid_reg;
    logic        done_reg, done_next;
    logic [1:0]  outcome_reg, outcome_next;
    logic [2:0]  cause_reg, cause_next;

    logic        accept;
    logic [31:0] r;
    logic [2:0]  status;
    eval_t       eval;

    // Input is taken whenever the result register is free or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign r        = read_data & bus_mask(paired_reg);

    nfts_eval u_eval (
        .paired        (paired_reg),
        .buffer_mode   (bufmode_reg),
        .pending_check (pending_reg),
        .first_read    (first_reg),
        .expected_held (expected_reg),
        .r             (r),
        .eval          (eval)
    );

    // Attempt status that ends the current pair.
    assign status = (phase_reg == PH_P2_R2) ? eval.p2_status : ST_BUSY;

    // Next poll state and result for the current read.
    always_comb
    begin
        phase_next    = phase_reg;
        pending_next  = pending_reg;
        first_next    = first_reg;
        attempts_next = attempts_reg;
        expected_next = expected_reg;
        bufmode_next  = bufmode_reg;
        final_next    = final_reg;
        done_next     = 1'b0;
        outcome_next  = OUT_OK;
        cause_next    = CAUSE_NONE;
        if (start_req) begin
            expected_next = expected_data;
            bufmode_next  = buffer_write;
            attempts_next = (limit_reg == 32'd0) ? 32'd0 : (limit_reg - 32'd1);
            pending_next  = CHK_NONE;
            final_next    = ST_READY;
            first_next    = r;
            phase_next    = PH_P1_R2;
        end else begin
            unique case (phase_reg)
                PH_P1_R1:
                begin
                    if (attempts_reg != 32'd0) begin
                        attempts_next = attempts_reg - 32'd1;
                    end
                    first_next = r;
                    phase_next = PH_P1_R2;
                end
                PH_P1_R2, PH_P2_R2:
                begin
                    if ((phase_reg == PH_P1_R2) && (eval.p1_check != CHK_NONE)) begin
                        pending_next = eval.p1_check;
                        phase_next   = PH_P2_R1;
                    end else begin
                        if (phase_reg == PH_P2_R2) begin
                            pending_next = CHK_NONE;
                        end
                        if (status != ST_BUSY) begin
                            final_next = status;
                            phase_next = PH_VERIFY;
                        end else if (attempts_reg != 32'd0) begin
                            phase_next = PH_P1_R1;
                        end else begin
                            final_next = ST_EXHAUSTED;
                            phase_next = PH_VERIFY;
                        end
                    end
                end
                PH_P2_R1:
                begin
                    first_next = r;
                    phase_next = PH_P2_R2;
                end
                PH_VERIFY:
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                    unique case (final_reg)
                        ST_READY:
                        begin
                            if (eval.verify_ok) begin
                                outcome_next = OUT_OK;
                                cause_next   = CAUSE_NONE;
                            end else begin
                                outcome_next = OUT_FAILED;
                                cause_next   = CAUSE_MISMATCH;
                            end
                        end
                        ST_ABORT:
                        begin
                            outcome_next = OUT_ABORTED;
                            cause_next   = CAUSE_ABORT;
                        end
                        ST_TIMEOUT:
                        begin
                            outcome_next = OUT_FAILED;
                            cause_next   = CAUSE_TIMEOUT;
                        end
                        ST_SUSPENDED:
                        begin
                            outcome_next = OUT_FAILED;
                            cause_next   = CAUSE_SUSPENDED;
                        end
                        default:
                        begin
                            outcome_next = OUT_FAILED;
                            cause_next   = CAUSE_EXHAUSTED;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            paired_reg <= 1'b0;
            limit_reg  <= 32'hFFFF_FFFF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PAIRED_MODE:   paired_reg <= cfg_data[0];
                REG_ATTEMPT_LIMIT: limit_reg  <= cfg_data;
                default:           paired_reg <= paired_reg;
            endcase
        end
    end

    // Poll state, updated once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_IDLE;
            pending_reg  <= CHK_NONE;
            first_reg    <= 32'd0;
            attempts_reg <= 32'd0;
            expected_reg <= 32'd0;
            bufmode_reg  <= 1'b0;
            final_reg    <= ST_READY;
        end else if (accept) begin
            phase_reg    <= phase_next;
            pending_reg  <= pending_next;
            first_reg    <= first_next;
            attempts_reg <= attempts_next;
            expected_reg <= expected_next;
            bufmode_reg  <= bufmode_next;
            final_reg    <= final_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            done_reg    <= done_next;
            outcome_reg <= outcome_next;
            cause_reg   <= cause_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign done_res  = done_reg;
    assign outcome   = outcome_reg;
    assign cause     = cause_reg;

endmodule

### verif/tb_nor_flash_toggle_status_poller_unit.sv
`timescale 1ns / 1ps
// Testbench for nor_flash_toggle_status_poller_unit: a directed table of status reads,
// then random poll sequences under several register settings, checked by a local model.
// Depends on nfts_pkg and the poller RTL.
module tb_nor_flash_toggle_status_poller_unit;
    import nfts_pkg::*;

    localparam int ITEMS_PER_SETTING = 225;
    localparam int SETTING_PHASES    = 8;
    localparam int LONG_HOLD_CYCLES  = 200;

    // One result item as the block reports it.
    typedef struct packed {
        logic       done;
        logic [1:0] outcome;
        logic [2:0] cause;
    } poll_result_t;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        logic         start;
        logic         bufw;
        logic [31:0]  exp;
        logic [31:0]  rd;
        logic         typed;
        poll_result_t want;
    } read_row_t;

    localparam poll_result_t NOT_DONE = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        start_req;
    logic        buffer_write;
    logic [31:0] expected_data;
    logic [31:0] read_data;
    logic        out_valid;
    logic        out_ready;
    logic        done_res;
    logic [1:0]  outcome;
    logic [2:0]  cause;

    // Model of the poll: register copies and poll state.
    logic        cfg_paired;
    logic [31:0] cfg_limit;
    logic [2:0]  poll_phase;
    logic [1:0]  poll_check;
    logic [31:0] poll_first;
    logic [31:0] poll_toggle;
    logic [31:0] poll_left;
    logic [31:0] poll_expect;
    logic        poll_bufmode;
    logic [2:0]  poll_status;

    poll_result_t expected_results[$];
    read_row_t    directed_rows[$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  finished_polls [0:5];
    logic sender_gaps = 1'b1;
    logic receiver_gaps = 1'b1;
    logic hold_off_req = 1'b0;

    nor_flash_toggle_status_poller_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_req     (start_req),
        .buffer_write  (buffer_write),
        .expected_data (expected_data),
        .read_data     (read_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .done_res      (done_res),
        .outcome       (outcome),
        .cause         (cause)
    );

    always #5 clk = ~clk;

    // Status bit in each device lane that is present.
    function automatic logic [31:0] dq_lanes(input logic [31:0] bit_mask);
        return cfg_paired ? (bit_mask | (bit_mask << 16)) : bit_mask;
    endfunction

    // Data bits that the bus carries in the current mode.
    function automatic logic [31:0] data_bits();
        return cfg_paired ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    endfunction

    // First read of an attempt uses up one attempt.
    function automatic void open_attempt(input logic [31:0] r);
        if (poll_left != 0)
            poll_left = poll_left - 1;
        poll_first = r;
        poll_phase = PH_P1_R2;
    endfunction

    // A busy attempt retries while attempts remain; anything else goes to the final read.
    function automatic void close_attempt(input logic [2:0] status);
        if (status == ST_BUSY && poll_left != 0) begin
            poll_phase = PH_P1_R1;
        end
        else begin
            poll_status = (status == ST_BUSY) ? ST_EXHAUSTED : status;
            poll_phase  = PH_VERIFY;
        end
    endfunction

    // Advance the poll by one status read and return the result it produces.
    function automatic poll_result_t step_poll(input logic start, input logic bufw,
                                               input logic [31:0] exp, input logic [31:0] rd);
        logic [31:0]  r;
        logic [31:0]  m6;
        logic [31:0]  m2;
        logic [31:0]  mk;
        logic [31:0]  t;
        logic [31:0]  d;
        logic [31:0]  hit;
        logic         abort_chk;
        poll_result_t res;
        r   = rd & data_bits();
        m6  = dq_lanes(DQ6_BIT);
        res = NOT_DONE;
        if (start) begin
            poll_expect  = exp;
            poll_bufmode = bufw;
            poll_left    = (cfg_limit == 0) ? 32'd1 : cfg_limit;
            poll_check   = CHK_NONE;
            poll_status  = ST_READY;
            open_attempt(r);
        end
        else begin
            case (poll_phase)
                PH_P1_R1: open_attempt(r);
                PH_P1_R2:
                begin
                    t = (poll_first ^ r) & m6;
                    poll_toggle = t;
                    if (t == 0) begin
                        poll_check = CHK_DQ2;
                        poll_phase = PH_P2_R1;
                    end
                    else if (poll_bufmode && ((t >> 5) & r) != 0) begin
                        poll_check = CHK_ABORT;
                        poll_phase = PH_P2_R1;
                    end
                    else if (((t >> 1) & r) != 0) begin
                        poll_check = CHK_TIMEOUT;
                        poll_phase = PH_P2_R1;
                    end
                    else begin
                        close_attempt(ST_BUSY);
                    end
                end
                PH_P2_R1:
                begin
                    poll_first = r;
                    poll_phase = PH_P2_R2;
                end
                PH_P2_R2:
                begin
                    if (poll_check == CHK_DQ2) begin
                        m2 = dq_lanes(DQ2_BIT);
                        d  = (poll_first ^ r) & m2;
                        close_attempt(d == m2 ? ST_SUSPENDED : (d == 0 ? ST_READY : ST_BUSY));
                    end
                    else begin
                        abort_chk = (poll_check == CHK_ABORT);
                        mk  = dq_lanes(abort_chk ? DQ1_BIT : DQ5_BIT);
                        t   = (poll_first ^ r) & m6;
                        poll_toggle = t;
                        hit = abort_chk ? (t >> 5) : (t >> 1);
                        if (t != 0 && (hit & r) != 0 && hit == (r & mk))
                            close_attempt(abort_chk ? ST_ABORT : ST_TIMEOUT);
                        else
                            close_attempt(ST_BUSY);
                    end
                    poll_check = CHK_NONE;
                end
                PH_VERIFY:
                begin
                    res.done = 1'b1;
                    case (poll_status)
                        ST_READY:
                        begin
                            if ((poll_expect & data_bits()) == r) begin
                                res.outcome = OUT_OK;
                                res.cause   = CAUSE_NONE;
                            end
                            else begin
                                res.outcome = OUT_FAILED;
                                res.cause   = CAUSE_MISMATCH;
                            end
                        end
                        ST_ABORT:
                        begin
                            res.outcome = OUT_ABORTED;
                            res.cause   = CAUSE_ABORT;
                        end
                        ST_TIMEOUT:
                        begin
                            res.outcome = OUT_FAILED;
                            res.cause   = CAUSE_TIMEOUT;
                        end
                        ST_SUSPENDED:
                        begin
                            res.outcome = OUT_FAILED;
                            res.cause   = CAUSE_SUSPENDED;
                        end
                        default:
                        begin
                            res.outcome = OUT_FAILED;
                            res.cause   = CAUSE_EXHAUSTED;
                        end
                    endcase
                    poll_phase = PH_IDLE;
                end
                default: poll_phase = PH_IDLE;
            endcase
        end
        return res;
    endfunction

    function automatic void add_row(input logic s, input logic b, input logic [31:0] e,
                                    input logic [31:0] rd, input logic typed,
                                    input poll_result_t want);
        read_row_t row;
        row = {s, b, e, rd, typed, want};
        directed_rows.push_back(row);
    endfunction

    // Choose the next read so that most polls follow the flash protocol and
    // reach every classification; the rest are restarts and stray reads.
    task automatic pick_item(output logic s, output logic b, output logic [31:0] e,
                             output logic [31:0] rd);
        int          roll;
        logic [31:0] m6;
        logic [31:0] m2;
        logic [31:0] mk;
        logic [31:0] tg;
        roll = $urandom_range(0, 99);
        s    = 1'b0;
        b    = 1'($urandom_range(0, 1));
        e    = $urandom;
        rd   = $urandom;
        m6   = dq_lanes(DQ6_BIT);
        m2   = dq_lanes(DQ2_BIT);
        if (poll_phase == PH_IDLE) begin
            s = (roll >= 6);
        end
        else if (roll < 3) begin
            s = 1'b1;
        end
        else begin
            case (poll_phase)
                PH_P1_R2:
                begin
                    case ($urandom_range(0, 2))
                        0: tg = '0;
                        1: tg = m6;
                        default: tg = m6 & $urandom;
                    endcase
                    rd = (rd & ~m6) | ((poll_first ^ tg) & m6);
                end
                PH_P2_R2:
                begin
                    if (poll_check == CHK_DQ2) begin
                        case ($urandom_range(0, 2))
                            0: tg = '0;
                            1: tg = m2;
                            default: tg = m2 & $urandom;
                        endcase
                        rd = (rd & ~m2) | ((poll_first ^ tg) & m2);
                    end
                    else if ($urandom_range(0, 3) != 0) begin
                        // Status bit set in exactly the lanes whose DQ6 still toggles.
                        tg = m6 & $urandom;
                        if (tg == 0)
                            tg = m6;
                        mk = dq_lanes(poll_check == CHK_ABORT ? DQ1_BIT : DQ5_BIT);
                        rd = (rd & ~(m6 | mk)) | ((poll_first ^ tg) & m6)
                           | ((poll_check == CHK_ABORT) ? (tg >> 5) : (tg >> 1));
                    end
                end
                PH_VERIFY:
                begin
                    if ($urandom_range(0, 1) != 0)
                        rd = (poll_expect & data_bits()) | (rd & ~data_bits());
                end
                default: ;
            endcase
        end
    endtask

    // Random gap on the sending side before the next item.
    task automatic pause_sender();
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Offer one item, wait for it to be taken, and record the result it must give.
    task automatic send_item(input logic s, input logic b, input logic [31:0] e,
                             input logic [31:0] rd, input logic typed,
                             input poll_result_t want);
        poll_result_t predicted;
        in_valid      <= 1'b1;
        start_req     <= s;
        buffer_write  <= b;
        expected_data <= e;
        read_data     <= rd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = step_poll(s, b, e, rd);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Both registers are written back to back while nothing is in flight.
    task automatic load_settings(input logic paired, input logic [31:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PAIRED_MODE;
        cfg_data  <= {31'd0, paired};
        @(posedge clk);
        cfg_index <= REG_ATTEMPT_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cfg_paired  = paired;
        cfg_limit   = limit;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [2:0] want_v,
                                        input logic [2:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Stimulus: reset, directed table, then one random block per register setting.
    initial begin
        logic        s;
        logic        b;
        logic        pm;
        logic [31:0] e;
        logic [31:0] rd;
        logic [31:0] lim;
        read_row_t   row;
        int          k;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_PAIRED_MODE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        start_req     = 1'b0;
        buffer_write  = 1'b0;
        expected_data = '0;
        read_data     = '0;
        cfg_paired    = 1'b0;
        cfg_limit     = 32'hFFFF_FFFF;
        poll_phase    = PH_IDLE;
        poll_check    = CHK_NONE;
        poll_first    = '0;
        poll_toggle   = '0;
        poll_left     = '0;
        poll_expect   = '0;
        poll_bufmode  = 1'b0;
        poll_status   = ST_READY;
        for (k = 0; k < 6; k++)
            finished_polls[k] = 0;

        // Stray read while idle, then a ready poll with all-ones data.
        add_row(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NOT_DONE);
        add_row(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b1, {1'b1, OUT_OK, CAUSE_NONE});
        // A poll abandoned by a new start, which then fails verify.
        add_row(1'b1, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b1, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0000_8000, 1'b1, {1'b1, OUT_FAILED, CAUSE_MISMATCH});
        // DQ2 toggles on the second pair: erase suspended.
        add_row(1'b1, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h4, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b1, {1'b1, OUT_FAILED, CAUSE_SUSPENDED});
        // Buffered write with DQ6 toggling and DQ1 set twice: write-buffer abort.
        add_row(1'b1, 1'b1, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h42, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h42, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b1, {1'b1, OUT_ABORTED, CAUSE_ABORT});
        // DQ6 toggling with DQ5 set twice: timeout.
        add_row(1'b1, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h60, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h60, 1'b0, NOT_DONE);
        add_row(1'b0, 1'b0, 32'h0, 32'h0, 1'b1, {1'b1, OUT_FAILED, CAUSE_TIMEOUT});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs with the reset register values.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            pause_sender();
            send_item(row.start, row.bufw, row.exp, row.rd, row.typed, row.want);
        end
        wait_drained();

        for (k = 0; k < SETTING_PHASES; k++) begin
            case (k)
                0: begin pm = 1'b1; lim = 32'd1;              end
                1: begin pm = 1'b0; lim = 32'd0;              end
                2: begin pm = 1'b1; lim = 32'hFFFF_FFFF;      end
                3: begin pm = 1'b0; lim = 32'd1;              end
                4: begin pm = 1'b1; lim = 32'd4;              end
                5: begin pm = 1'b0; lim = $urandom;           end
                6: begin pm = 1'($urandom_range(0, 1)); lim = $urandom_range(1, 5); end
                default: begin pm = 1'b1; lim = 32'd2;        end
            endcase
            // Back-to-back stretch in the middle and at the very end.
            sender_gaps   = (k != 3 && k != SETTING_PHASES - 1);
            receiver_gaps = sender_gaps;
            load_settings(pm, lim);
            if (k == 4)
                hold_off_req = 1'b1;
            repeat (ITEMS_PER_SETTING) begin
                pick_item(s, b, e, rd);
                pause_sender();
                send_item(s, b, e, rd, 1'b0, NOT_DONE);
            end
            wait_drained();
        end

        // A few idle cycles to catch any stray result.
        repeat (4) @(posedge clk);
        $display("Sent %0d status reads: %0d directed, the rest random over %0d settings.",
                 items_sent, directed_rows.size(), SETTING_PHASES);
        $display("Polls done: ok %0d, abort %0d, timeout %0d, suspended %0d, %s",
                 finished_polls[0], finished_polls[1], finished_polls[2],
                 finished_polls[3], "attempts and verify below.");
        $display("Polls done: exhausted %0d, verify mismatch %0d.",
                 finished_polls[4], finished_polls[5]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: random stalls, and one long hold-off so the block backs up.
    initial begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin : result_check
        poll_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: done_res %0d outcome %0d cause %0d",
                         $time, done_res, outcome, cause);
                mismatch_count++;
            end
            else begin
                want = expected_results.pop_front();
                check_field("done_res", {2'b0, want.done}, {2'b0, done_res});
                check_field("outcome", {1'b0, want.outcome}, {1'b0, outcome});
                check_field("cause", want.cause, cause);
                if (done_res === 1'b1 && cause <= CAUSE_MISMATCH)
                    finished_polls[cause]++;
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("%0t: run did not complete in time", $time);
        $display("Mismatches found");
        $finish;
    end

endmodule
